/* design/u8sd_pkg.sv */
// u8sd_pkg: shared widths, constants and types for the UTF-8 stream decoder.
// No dependencies; imported by u8sd_decode and utf8_stream_decoder.
package u8sd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CodePointW = 31;
  localparam int unsigned CharIdxW  = 16;
  localparam int unsigned LeftW     = 3;
  localparam int unsigned CountWidthDefault = 16;

  // Payload bits carried by each continuation byte
  localparam logic [ByteW-1:0] ContMask = 8'h3F;

  // Sequence state held between words
  typedef struct packed {
    logic [LeftW-1:0]      bytes_left;
    logic [CodePointW-1:0] accum;
    logic                  lead_invalid;
  } u8sd_state_t;

  // Result fields except the character index
  typedef struct packed {
    logic [CodePointW-1:0] code_point;
    logic                  bad_lead;
    logic                  end_of_text;
    logic                  truncated;
  } u8sd_result_t;

  // Step outcome: emit flag and character counter control
  typedef struct packed {
    logic emit;
    logic ctr_clear;
    logic ctr_advance;
  } u8sd_ctrl_t;

endpackage

/* design/u8sd_decode.sv */
// u8sd_decode: combinational step of the decoder for one input word.
// Depends on u8sd_pkg for the state, result and control types.
module u8sd_decode (
  input  logic [u8sd_pkg::ByteW-1:0] byte_in_i,
  input  u8sd_pkg::u8sd_state_t      state_i,
  output u8sd_pkg::u8sd_state_t      state_o,
  output u8sd_pkg::u8sd_result_t     result_o,
  output u8sd_pkg::u8sd_ctrl_t       ctrl_o
);
  import u8sd_pkg::*;

  logic [CodePointW-1:0] accum_shift;
  logic [LeftW-1:0]      left_dec;

  // Shift six payload bits into the accumulator, drop bits above bit 30
  assign accum_shift = {state_i.accum[CodePointW-7:0], byte_in_i[5:0] & ContMask[5:0]};
  assign left_dec    = state_i.bytes_left - LeftW'(1);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    ctrl_o   = '0;
    if (state_i.bytes_left == '0) begin
      if (byte_in_i == '0) begin
        // Terminator at a character boundary: end text, restart index
        ctrl_o.emit          = 1'b1;
        ctrl_o.ctr_clear     = 1'b1;
        result_o.end_of_text = 1'b1;
      end else if (!byte_in_i[7]) begin
        // Plain ASCII character
        ctrl_o.emit         = 1'b1;
        ctrl_o.ctr_advance  = 1'b1;
        result_o.code_point = CodePointW'(byte_in_i);
      end else begin
        // Lead byte: set length and seed the accumulator
        state_o.lead_invalid = 1'b0;
        case (byte_in_i) inside
          [8'hC0:8'hDF]: begin
            state_o.accum      = CodePointW'(byte_in_i[4:0]);
            state_o.bytes_left = LeftW'(1);
          end
          [8'hE0:8'hEF]: begin
            state_o.accum      = CodePointW'(byte_in_i[3:0]);
            state_o.bytes_left = LeftW'(2);
          end
          [8'hF0:8'hF7]: begin
            state_o.accum      = CodePointW'(byte_in_i[2:0]);
            state_o.bytes_left = LeftW'(3);
          end
          [8'hF8:8'hFB]: begin
            state_o.accum      = CodePointW'(byte_in_i[1:0]);
            state_o.bytes_left = LeftW'(4);
          end
          [8'hFC:8'hFD]: begin
            state_o.accum      = CodePointW'(byte_in_i[0]);
            state_o.bytes_left = LeftW'(5);
          end
          default: begin
            // Stray continuation byte or 0xFE/0xFF: swallow six bytes
            state_o.accum        = '0;
            state_o.lead_invalid = 1'b1;
            state_o.bytes_left   = LeftW'(5);
          end
        endcase
      end
    end else if (byte_in_i == '0) begin
      // Terminator inside a sequence: abort it and end the text
      ctrl_o.emit          = 1'b1;
      ctrl_o.ctr_clear     = 1'b1;
      result_o.bad_lead    = state_i.lead_invalid;
      result_o.end_of_text = 1'b1;
      result_o.truncated   = 1'b1;
      state_o              = '0;
    end else begin
      // Continuation byte: accumulate, finish on the last one
      state_o.accum      = accum_shift;
      state_o.bytes_left = left_dec;
      if (left_dec == '0) begin
        ctrl_o.emit          = 1'b1;
        ctrl_o.ctr_advance   = 1'b1;
        result_o.bad_lead    = state_i.lead_invalid;
        result_o.code_point  = state_i.lead_invalid ? '0 : accum_shift;
        state_o.accum        = '0;
        state_o.lead_invalid = 1'b0;
      end
    end
  end

endmodule

/* design/utf8_stream_decoder.sv */
// utf8_stream_decoder: top level; sequence state, character counter, result register.
// Depends on u8sd_pkg and u8sd_decode.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------------
//   in      | in_valid_i, in_ready_o | byte_in_i
//   out     | out_valid_o, out_ready_i | code_point_o, char_index_o, bad_lead_o,
//           |                        | end_of_text_o, truncated_o
//
// One word per cycle while a held result is not stalled by a low out_ready_i:
// each byte is decoded in a single combinational step between the sequence state registers and the result register.
// A completed character appears on the output in the cycle after its last byte is taken.
// Reset clears the sequence state, the counter and the output valid.
// A held result stalls input only if out_ready_i is low; otherwise a new
// word is taken in the same cycle the result leaves.
module utf8_stream_decoder #(
  parameter int unsigned CountWidth = u8sd_pkg::CountWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [u8sd_pkg::ByteW-1:0]       byte_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [u8sd_pkg::CodePointW-1:0]  code_point_o,
  output logic [u8sd_pkg::CharIdxW-1:0]    char_index_o,
  output logic                             bad_lead_o,
  output logic                             end_of_text_o,
  output logic                             truncated_o
);
  import u8sd_pkg::*;

  u8sd_state_t           state_q, state_d;
  u8sd_result_t          result_d, result_q;
  u8sd_ctrl_t            ctrl;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CharIdxW-1:0]   index_d, index_q;
  logic [CountWidth+CharIdxW-1:0] count_ext;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;

  // Take a word when the result register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  u8sd_decode u_decode (
    .byte_in_i (byte_in_i),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (result_d),
    .ctrl_o    (ctrl)
  );

  // Low bits of the counter, zero-extended for narrow counters
  assign count_ext = {{CharIdxW{1'b0}}, count_q};
  assign index_d   = count_ext[CharIdxW-1:0];

  // Advance with saturation, or clear at end of text
  always_comb begin
    count_d = count_q;
    if (ctrl.ctr_clear) begin
      count_d = '0;
    end else if (ctrl.ctr_advance && (count_q != '1)) begin
      count_d = count_q + CountWidth'(1);
    end
  end

  // Hold output valid until taken, set it when a word emits
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (accept && ctrl.emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Sequence state, counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
        count_q <= count_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && ctrl.emit) begin
      result_q <= result_d;
      index_q  <= index_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = result_q.code_point;
  assign char_index_o  = index_q;
  assign bad_lead_o    = result_q.bad_lead;
  assign end_of_text_o = result_q.end_of_text;
  assign truncated_o   = result_q.truncated;

endmodule
